### rtl/ptt_pkg.sv
`default_nettype none
package ptt_pkg;

  // Table size and derived widths
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int USED_W     = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W      = (USED_W > 4) ? USED_W : 4;

  // Field widths
  localparam int TIME_W = 16;
  localparam int ID_W   = 4;

  localparam logic [TIME_W-1:0] DEFAULT_TIMEOUT_RST = 16'd1000;

  // Command codes
  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_TICK    = 3'd2,
    CMD_PROCESS = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BAD_ID = 2'd2
  } status_t;

  // One timer slot as it travels round the ring
  typedef struct packed {
    logic              enabled;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] period;
  } entry_t;

endpackage
`default_nettype wire

### rtl/ptt_cell.sv
`default_nettype none
module ptt_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire ptt_pkg::entry_t d,
  output ptt_pkg::entry_t      q
);

  // Hold the active flag; only it needs a known value after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q.enabled <= 1'b0;
    end else if (shift) begin
      q.enabled <= d.enabled;
    end
  end

  // Hold the countdown and reload value; take the neighbour's on a shift
  always_ff @(posedge clk) begin
    if (shift) begin
      q.remaining <= d.remaining;
      q.period    <= d.period;
    end
  end

endmodule
`default_nettype wire

### rtl/periodic_timer_table_unit.sv
`default_nettype none
// Table of periodic millisecond timers held in a ring of slot cells. Every
// command rotates the ring once: slot k passes the head cell at step k of
// the scan, where it is added, removed, ticked, checked for expiry or
// folded into the query minimum. An item is taken in S_IDLE, scanned over
// all SLOT_COUNT slots in S_SCAN, and posts its final result in S_FINISH.
// A new item is taken once that final result is in the output register,
// and the final result waits for that register to be free.
// A process command pauses the rotation whenever an expired slot is found
// while the previous report is still pending and the output register is
// occupied. Reports of a process come out in slot order with last set on
// the final one. A process with nothing expired gives one empty result.
// default_timeout is written over the cfg channel, which is always ready.
module periodic_timer_table_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  // command items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  command,
  input  wire logic [3:0]  slot_id,
  input  wire logic [15:0] period_ms,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [3:0]       result_id,
  output logic [15:0]      timeout_ms,
  output logic             fired,
  output logic             last
);

  localparam int N      = ptt_pkg::SLOT_COUNT;
  localparam int SLOT_W = ptt_pkg::SLOT_W;
  localparam int USED_W = ptt_pkg::USED_W;
  localparam int CMP_W  = ptt_pkg::CMP_W;
  localparam int TIME_W = ptt_pkg::TIME_W;
  localparam logic [SLOT_W-1:0] STEP_LAST = SLOT_W'(N - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t              state;
  logic [SLOT_W-1:0]   step;
  ptt_pkg::cmd_t       cmd_q;
  logic [3:0]          sid_q;
  logic [TIME_W-1:0]   per_q;
  logic [TIME_W-1:0]   best;
  logic                pend_valid;
  logic [SLOT_W-1:0]   pend_id;
  logic [USED_W-1:0]   used_slots;
  logic [TIME_W-1:0]   default_timeout;

  ptt_pkg::entry_t     ring_q [N];
  ptt_pkg::entry_t     head;
  ptt_pkg::entry_t     head_next;
  logic                hit_fire;
  logic                out_free;
  logic                advance;
  logic                shift;
  logic                add_ok;
  logic                rm_ok;
  logic                out_load;
  ptt_pkg::status_t    status_next;
  logic [3:0]          result_id_next;
  logic [TIME_W-1:0]   timeout_ms_next;
  logic                fired_next;
  logic                last_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign add_ok = (used_slots < USED_W'(N));
  assign rm_ok  = (CMP_W'(sid_q) < CMP_W'(used_slots));

  // Ring of slot cells; the head feeds back into the tail
  assign head = ring_q[0];

  for (genvar k = 0; k < N; k++) begin : g_cell
    ptt_pkg::entry_t d_k;
    if (k == N - 1) begin : g_tail
      assign d_k = head_next;
    end else begin : g_mid
      assign d_k = ring_q[k+1];
    end
    ptt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d_k),
      .q     (ring_q[k])
    );
  end

  // Apply the command to the slot passing the head
  always_comb begin
    head_next = head;
    hit_fire  = 1'b0;
    case (cmd_q)
      ptt_pkg::CMD_ADD: begin
        if (add_ok && (CMP_W'(step) == CMP_W'(used_slots))) begin
          head_next.enabled   = 1'b1;
          head_next.remaining = per_q;
          head_next.period    = per_q;
        end
      end
      ptt_pkg::CMD_REMOVE: begin
        if (rm_ok && (CMP_W'(step) == CMP_W'(sid_q))) begin
          head_next.enabled = 1'b0;
        end
      end
      ptt_pkg::CMD_TICK: begin
        if (head.enabled && (head.remaining != '0)) begin
          head_next.remaining = head.remaining - TIME_W'(1);
        end
      end
      ptt_pkg::CMD_PROCESS: begin
        if (head.enabled && (head.remaining == '0)) begin
          hit_fire            = 1'b1;
          head_next.remaining = head.period;
        end
      end
      default: begin
      end
    endcase
  end

  // Stall the ring when a report must go out but the output is occupied
  assign advance = !(hit_fire && pend_valid && !out_free);
  assign shift   = (state == S_SCAN) && advance;

  // Load the output with the previous report during a scan, or with the
  // final result once the scan is done
  assign out_load = ((state == S_SCAN) && advance && hit_fire && pend_valid) ||
                    ((state == S_FINISH) && out_free);

  // Build the next result item
  always_comb begin
    status_next     = ptt_pkg::ST_OK;
    result_id_next  = '0;
    timeout_ms_next = '0;
    fired_next      = 1'b0;
    last_next       = 1'b1;
    if (state == S_SCAN) begin
      result_id_next = 4'(pend_id);
      fired_next     = 1'b1;
      last_next      = 1'b0;
    end else begin
      case (cmd_q)
        ptt_pkg::CMD_ADD: begin
          if (add_ok) begin
            result_id_next = 4'(used_slots);
          end else begin
            status_next = ptt_pkg::ST_FULL;
          end
        end
        ptt_pkg::CMD_REMOVE: begin
          if (!rm_ok) begin
            status_next = ptt_pkg::ST_BAD_ID;
          end
        end
        ptt_pkg::CMD_PROCESS: begin
          if (pend_valid) begin
            result_id_next = 4'(pend_id);
            fired_next     = 1'b1;
          end
        end
        ptt_pkg::CMD_QUERY: begin
          timeout_ms_next = best;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer, configuration register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      step            <= '0;
      pend_valid      <= 1'b0;
      used_slots      <= '0;
      default_timeout <= ptt_pkg::DEFAULT_TIMEOUT_RST;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        default_timeout <= cfg_data;
      end
      if (out_load) begin
        out_valid  <= 1'b1;
        status     <= status_next;
        result_id  <= result_id_next;
        timeout_ms <= timeout_ms_next;
        fired      <= fired_next;
        last       <= last_next;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q      <= ptt_pkg::cmd_t'(command);
            sid_q      <= slot_id;
            per_q      <= period_ms;
            best       <= default_timeout;
            pend_valid <= 1'b0;
            step       <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (advance) begin
            // keep the new report pending; the previous one has gone out
            if (hit_fire) begin
              pend_valid <= 1'b1;
              pend_id    <= step;
            end
            if ((cmd_q == ptt_pkg::CMD_QUERY) && head.enabled &&
                (head.remaining < best)) begin
              best <= head.remaining;
            end
            if (step == STEP_LAST) begin
              state <= S_FINISH;
            end else begin
              step <= step + SLOT_W'(1);
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            if ((cmd_q == ptt_pkg::CMD_ADD) && add_ok) begin
              used_slots <= used_slots + USED_W'(1);
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/ptt_checker.sv
`default_nettype none
module ptt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [3:0]  result_id,
  input wire logic [15:0] timeout_ms,
  input wire logic        fired,
  input wire logic        last
);

  // Hold a stalled result item unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(result_id) && $stable(timeout_ms) && $stable(fired) && $stable(last))
    else $error("stalled result item changed");

  // An accepted item keeps the input closed as the scan begins
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input reopened during scan");

  // A firing report carries no error and no timeout
  a_fired_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> status == ptt_pkg::ST_OK && timeout_ms == 16'd0)
    else $error("fired report with status or timeout");

  // An error result is single, final and carries no slot
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ptt_pkg::ST_OK |-> last && !fired && result_id == 4'd0)
    else $error("error result malformed");

  // A result that is not the last must be a firing report
  a_not_last_fired: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> fired)
    else $error("non-final result is not a firing report");

endmodule

bind periodic_timer_table_unit ptt_checker u_ptt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .result_id  (result_id),
  .timeout_ms (timeout_ms),
  .fired      (fired),
  .last       (last)
);
`default_nettype wire
